FILE: src/sfbf_pkg.sv
// sfbf_pkg: shared types and constants of the syn flood blacklist filter
// depends on nothing; imported by every module of the block but sfbf_ram

package sfbf_pkg;

  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [15:0] THRESHOLD_RESET = 16'd50;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

  // register index of syn_threshold in the apb map
  localparam logic        REG_SYN_THRESHOLD = 1'b0;

  // item queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_BLOCKED = 2'd1,
    CAUSE_FLOOD   = 2'd2
  } drop_cause_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } back_state_t;

  // one classified word as it travels through the queue
  typedef struct packed {
    logic [31:0] addr;
    logic        syn_only;
  } sfbf_item_t;

  // queue handshake seen by the front
  typedef struct packed {
    logic       push;
    sfbf_item_t item;
  } sfbf_push_t;

endpackage

FILE: src/sfbf_ram.sv
// sfbf_ram: generic single-write, single-read ram with registered read data
// depends on nothing

module sfbf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/sfbf_fifo.sv
// sfbf_fifo: short flop-based queue carrying classified words front to back
// depends on sfbf_pkg

module sfbf_fifo
  import sfbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sfbf_push_t wr,
  output logic       full,
  input  logic       pop,
  output sfbf_item_t rd_item,
  output logic       empty
);

  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  sfbf_item_t          slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]    fill;
  logic                do_push;
  logic                do_pop;

  assign full    = (fill == CNT_W'(Q_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = wr.push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: src/sfbf_front.sv
// sfbf_front: takes header words and classifies them as bare syn or other
// depends on sfbf_pkg

module sfbf_front
  import sfbf_pkg::*;
(
  input  logic        start,
  output logic        busy,
  input  logic [31:0] source_addr,
  input  logic [7:0]  ip_protocol,
  input  logic        flag_syn,
  input  logic        flag_ack,
  input  logic        flag_urg,
  input  logic        flag_rst,
  input  logic        flag_fin,
  input  logic        flag_psh,
  input  logic        q_full,
  output sfbf_push_t  q_wr
);

  logic syn_only;

  // tcp with syn as the only flag set
  assign syn_only = (ip_protocol == PROTO_TCP) && flag_syn && !flag_ack && !flag_urg &&
                    !flag_rst && !flag_fin && !flag_psh;

  assign busy               = q_full;
  assign q_wr.push          = start && !q_full;
  assign q_wr.item.addr     = source_addr;
  assign q_wr.item.syn_only = syn_only;

endmodule

FILE: src/sfbf_back.sv
// sfbf_back: scans the blocked table, keeps the syn counter, issues verdicts
// depends on sfbf_pkg and sfbf_ram

module sfbf_back
  import sfbf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] syn_threshold,
  input  logic        q_empty,
  input  sfbf_item_t  q_item,
  output logic        q_pop,
  output logic        done,
  output logic        drop,
  output logic [1:0]  drop_cause,
  output logic        address_added,
  output logic        table_full
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  back_state_t  state, state_next;
  logic [31:0]  cur_addr, cur_addr_next;
  logic         cur_syn, cur_syn_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic         cmp_vld, cmp_vld_next;
  logic [CNT_W-1:0] blocked_count, blocked_count_next;
  logic [15:0]  syn_count, syn_count_next;
  logic         done_next;
  logic         drop_next;
  drop_cause_t  drop_cause_next;
  logic         address_added_next;
  logic         table_full_next;

  logic         ram_rd_en;
  logic         ram_wr_en;
  logic [31:0]  ram_rd_data;
  logic [15:0]  syn_inc;
  logic         hit;

  sfbf_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (blocked_count[IDX_W-1:0]),
    .wr_data (cur_addr),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // counter saturates at its top value
  assign syn_inc = (syn_count != COUNT_MAX) ? syn_count + 16'd1 : syn_count;
  assign hit     = cmp_vld && (ram_rd_data == cur_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cmp_vld       <= 1'b0;
      blocked_count <= '0;
      syn_count     <= '0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      cmp_vld       <= cmp_vld_next;
      blocked_count <= blocked_count_next;
      syn_count     <= syn_count_next;
      done          <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_addr      <= cur_addr_next;
    cur_syn       <= cur_syn_next;
    rd_idx        <= rd_idx_next;
    drop          <= drop_next;
    drop_cause    <= drop_cause_next;
    address_added <= address_added_next;
    table_full    <= table_full_next;
  end

  always_comb begin
    state_next         = state;
    cur_addr_next      = cur_addr;
    cur_syn_next       = cur_syn;
    rd_idx_next        = rd_idx;
    cmp_vld_next       = cmp_vld;
    blocked_count_next = blocked_count;
    syn_count_next     = syn_count;
    done_next          = 1'b0;
    drop_next          = drop;
    drop_cause_next    = drop_cause_t'(drop_cause);
    address_added_next = address_added;
    table_full_next    = table_full;
    q_pop              = 1'b0;
    ram_rd_en          = 1'b0;
    ram_wr_en          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          cur_addr_next = q_item.addr;
          cur_syn_next  = q_item.syn_only;
          rd_idx_next   = '0;
          cmp_vld_next  = 1'b0;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (hit) begin
          done_next          = 1'b1;
          drop_next          = 1'b1;
          drop_cause_next    = CAUSE_BLOCKED;
          address_added_next = 1'b0;
          table_full_next    = 1'b0;
          cmp_vld_next       = 1'b0;
          state_next         = ST_IDLE;
        end else if (rd_idx < blocked_count) begin
          // read next entry while comparing the one before
          ram_rd_en    = 1'b1;
          rd_idx_next  = rd_idx + CNT_W'(1);
          cmp_vld_next = 1'b1;
        end else begin
          done_next          = 1'b1;
          drop_next          = 1'b0;
          drop_cause_next    = CAUSE_NONE;
          address_added_next = 1'b0;
          table_full_next    = 1'b0;
          cmp_vld_next       = 1'b0;
          state_next         = ST_IDLE;
          if (cur_syn) begin
            if (syn_inc > syn_threshold) begin
              drop_next       = 1'b1;
              drop_cause_next = CAUSE_FLOOD;
              syn_count_next  = '0;
              if (blocked_count < CNT_W'(TABLE_DEPTH)) begin
                ram_wr_en          = 1'b1;
                blocked_count_next = blocked_count + CNT_W'(1);
                address_added_next = 1'b1;
              end else begin
                table_full_next = 1'b1;
              end
            end else begin
              syn_count_next = syn_inc;
            end
          end
        end
      end
    endcase
  end

endmodule

FILE: src/syn_flood_blacklist_filter.sv
// syn_flood_blacklist_filter: top level, apb register and front/queue/back
// depends on sfbf_pkg, sfbf_front, sfbf_fifo, sfbf_back (and sfbf_ram below it)
//
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------------------
// in       | start, busy                | source_addr, ip_protocol, flag_* (six)
// out      | done (one-cycle strobe)    | drop, drop_cause, address_added, table_full
// config   | psel, penable, pwrite,     | paddr, pwdata, prdata (syn_threshold at 0)
//          | pready                     |
//
// a word is taken at an edge with start high and busy low; a two-word queue
// lets the front take words while the back works, busy is high when it fills
// the back takes no new word until it is through with the last: it pops the
// queue, reads each stored entry from the table ram (one read port) while it
// compares the one read before, then makes the last compare and the verdict;
// a match ends the scan at that entry; the receiver cannot stall: done is high
// for one cycle only, and drop, drop_cause, address_added and table_full hold
// until the next verdict; synchronous reset empties the queue and the table and
// clears the syn counter; syn_threshold returns to 50

module syn_flood_blacklist_filter
  import sfbf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // header words
  input  logic        start,
  output logic        busy,
  input  logic [31:0] source_addr,
  input  logic [7:0]  ip_protocol,
  input  logic        flag_syn,
  input  logic        flag_ack,
  input  logic        flag_urg,
  input  logic        flag_rst,
  input  logic        flag_fin,
  input  logic        flag_psh,
  // verdicts
  output logic        done,
  output logic        drop,
  output logic [1:0]  drop_cause,
  output logic        address_added,
  output logic        table_full,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] syn_threshold;
  logic        reg_sel;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  sfbf_push_t  q_wr;
  sfbf_item_t  q_item;

  // register file: one 32-bit slot, bit 2 of the address picks beyond it
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_SYN_THRESHOLD);
  assign prdata  = reg_sel ? {16'd0, syn_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      syn_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      syn_threshold <= pwdata[15:0];
    end
  end

  // front: classify and push
  sfbf_front u_front (
    .start       (start),
    .busy        (busy),
    .source_addr (source_addr),
    .ip_protocol (ip_protocol),
    .flag_syn    (flag_syn),
    .flag_ack    (flag_ack),
    .flag_urg    (flag_urg),
    .flag_rst    (flag_rst),
    .flag_fin    (flag_fin),
    .flag_psh    (flag_psh),
    .q_full      (q_full),
    .q_wr        (q_wr)
  );

  // queue between the two halves
  sfbf_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  // back: table scan, counter and verdict
  sfbf_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .syn_threshold (syn_threshold),
    .q_empty       (q_empty),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .done          (done),
    .drop          (drop),
    .drop_cause    (drop_cause),
    .address_added (address_added),
    .table_full    (table_full)
  );

endmodule
